// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle assertion failed");

`endif

// ===== sv/dce_pkg.sv =====
// Package with the shared constants and codes of the diffusion centrality engine.
package dce_pkg;

    // Default sizes.
    localparam int DEF_MAX_NODES     = 32;
    localparam int DEF_VALUE_BITS    = 48;
    localparam int DEF_FRACTION_BITS = 16;

    // Results of one run never exceed this count.
    localparam int RESULT_LIMIT = 32;

    // Input command codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] REG_HORIZON    = 1'b0;
    localparam logic [0:0] REG_NODE_COUNT = 1'b1;

    // Edge weight codes held in the adjacency store.
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_HALF = 2'd1;
    localparam logic [1:0] W_ONE  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [4:0] HORIZON_RESET    = 5'd2;
    localparam logic [5:0] NODE_COUNT_RESET = 6'd32;

endpackage

// ===== sv/diffusion_centrality_engine_unit.sv =====
// Top level of the diffusion centrality engine: edge store, matrix power unit and result output.
//
// Usage:
// - The input channel (in_valid/in_ready) carries one command per transaction. A load
//   (func = 0) writes edge from_node -> to_node into the adjacency store; the first
//   weight loaded for an edge is kept. Loads are taken one per cycle.
// - A run (func = 1) computes row and column diffusion centrality for the first n
//   nodes and returns n result transactions on the output channel, node 0 first,
//   with last set on the final one. The adjacency store is cleared afterwards.
// - After the last result, a run ends with a clearing sweep of one adjacency entry
//   per cycle over all 2^(2*ceil(log2(MAX_NODES))) entries (1024 by default). The
//   run is paced by the single multiply-accumulate path over the power memory, one
//   product term per cycle.
// - Input is held off (in_ready low) from the run transaction until the clearing
//   sweep ends. While the receiver stalls, the current result is held and the
//   engine waits.
// - After reset the same clearing sweep runs before the first transaction is taken.
// - The configuration channel (cfg_valid/cfg_ready), always ready, writes horizon (index 0)
//   and node_count (index 1); the user writes it only while idle, the block does not check.
module diffusion_centrality_engine_unit #(
    parameter int MAX_NODES     = dce_pkg::DEF_MAX_NODES,
    parameter int VALUE_BITS    = dce_pkg::DEF_VALUE_BITS,
    parameter int FRACTION_BITS = dce_pkg::DEF_FRACTION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [4:0]            from_node,
    input  logic [4:0]            to_node,
    input  logic                  certain,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [4:0]            node,
    output logic [VALUE_BITS-1:0] row_centrality,
    output logic [VALUE_BITS-1:0] col_centrality,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [5:0]            cfg_data
);
    import dce_pkg::*;

    localparam int IW   = $clog2(MAX_NODES);
    localparam int AW   = 2 * IW;
    localparam int NLIM = (MAX_NODES < RESULT_LIMIT) ? MAX_NODES : RESULT_LIMIT;
    localparam logic [VALUE_BITS-1:0] VMAX     = '1;
    localparam logic [VALUE_BITS-1:0] FIX_ONE  = VALUE_BITS'(1) << FRACTION_BITS;
    localparam logic [6:0]            NLIM_VAL = 7'(NLIM);
    localparam logic [6:0]            MAX_VAL  = 7'(MAX_NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_MUL, S_MDRAIN, S_ACC, S_ADRAIN,
        S_OREAD, S_OLOAD, S_OUT
    } state_t;

    // Saturating add at the value width.
    function automatic logic [VALUE_BITS-1:0] sat_add(
        input logic [VALUE_BITS-1:0] a,
        input logic [VALUE_BITS-1:0] b
    );
        logic [VALUE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_BITS] ? VMAX : s[VALUE_BITS-1:0];
    endfunction

    // Control and payload registers.
    state_t                state_reg, state_next;
    logic [4:0]            horizon_reg, horizon_next;
    logic [5:0]            node_count_reg, node_count_next;
    logic [IW-1:0]         j_reg, j_next, k_reg, k_next, h_reg, h_next;
    logic [4:0]            t_reg, t_next;
    logic [AW-1:0]         cl_reg, cl_next;
    logic                  ld_v_reg, ld_v_next;
    logic [AW-1:0]         ld_idx_reg, ld_idx_next;
    logic [1:0]            ld_w_reg, ld_w_next;
    logic                  lw_v_reg, lw_v_next;
    logic [AW-1:0]         lw_idx_reg, lw_idx_next;
    logic [1:0]            lw_w_reg, lw_w_next;
    logic                  m_v_reg, m_v_next, m_first_reg, m_first_next;
    logic                  m_last_reg, m_last_next, m_diag_reg, m_diag_next;
    logic [IW-1:0]         m_j_reg, m_j_next, m_k_reg, m_k_next;
    logic [VALUE_BITS-1:0] s_reg, s_next;
    logic                  a_v_reg, a_v_next, a_first_reg, a_first_next;
    logic                  a_last_reg, a_last_next;
    logic [IW-1:0]         a_j_reg, a_j_next;
    logic [VALUE_BITS-1:0] rt_reg, rt_next, ct_reg, ct_next;
    logic                  out_valid_reg, out_valid_next;
    logic [4:0]            node_reg, node_next;
    logic [VALUE_BITS-1:0] row_reg, row_next, col_reg, col_next;
    logic                  last_reg, last_next;

    // Memory ports.
    logic [1:0]            wmem [2**AW];
    logic [1:0]            w_rd_reg;
    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [1:0]            w_wdata;
    logic [VALUE_BITS-1:0] pmem [2**(AW+1)];
    logic [VALUE_BITS-1:0] p_rd1_reg, p_rd2_reg;
    logic                  p_we;
    logic [AW:0]           p_wa, p_ra1, p_ra2;
    logic [VALUE_BITS-1:0] p_wd;
    logic [VALUE_BITS-1:0] rmem [2**IW];
    logic [VALUE_BITS-1:0] cmem [2**IW];
    logic [VALUE_BITS-1:0] rs_rd_reg, cs_rd_reg;
    logic                  s_we, s_re;
    logic [IW-1:0]         s_wa, s_ra;
    logic [VALUE_BITS-1:0] r_wd, c_wd;

    // Effective run size and horizon.
    logic [6:0]      n_eff;
    logic [IW-1:0]   nm1;
    logic [4:0]      hz_eff;
    logic            in_range;
    logic [1:0]      w_eff;
    logic [VALUE_BITS-1:0] prev_val, term, s_new, rt_new, ct_new, row_old, col_old;

    always_comb
    begin
        if (node_count_reg == 6'd0)
        begin
            n_eff = 7'd1;
        end
        else if ({1'b0, node_count_reg} > NLIM_VAL)
        begin
            n_eff = NLIM_VAL;
        end
        else
        begin
            n_eff = {1'b0, node_count_reg};
        end
        nm1    = IW'(n_eff - 7'd1);
        hz_eff = (horizon_reg == 5'd0) ? 5'd1 : horizon_reg;
    end

    assign in_range = ({2'b0, from_node} < MAX_VAL) && ({2'b0, to_node} < MAX_VAL);
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid      = out_valid_reg;
    assign node           = node_reg;
    assign row_centrality = row_reg;
    assign col_centrality = col_reg;
    assign last           = last_reg;

    // Adjacency store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        w_rd_reg <= wmem[w_raddr];
    end

    // Power memory: two banks, one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_wa] <= p_wd;
        end
        p_rd1_reg <= pmem[p_ra1];
        p_rd2_reg <= pmem[p_ra2];
    end

    // Row and column accumulators.
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            rmem[s_wa] <= r_wd;
            cmem[s_wa] <= c_wd;
        end
        if (s_re)
        begin
            rs_rd_reg <= rmem[s_ra];
            cs_rd_reg <= cmem[s_ra];
        end
    end

    // Datapath of the multiply and accumulate stages.
    always_comb
    begin
        w_eff = (lw_v_reg && (lw_idx_reg == ld_idx_reg)) ? lw_w_reg : w_rd_reg;
        if (t_reg == 5'd1)
        begin
            prev_val = m_diag_reg ? FIX_ONE : '0;
        end
        else
        begin
            prev_val = p_rd1_reg;
        end
        case (w_rd_reg)
            W_ONE:   term = prev_val;
            W_HALF:  term = prev_val >> 1;
            default: term = '0;
        endcase
        s_new   = m_first_reg ? term : sat_add(s_reg, term);
        rt_new  = a_first_reg ? p_rd1_reg : sat_add(rt_reg, p_rd1_reg);
        ct_new  = a_first_reg ? p_rd2_reg : sat_add(ct_reg, p_rd2_reg);
        row_old = (t_reg == 5'd1) ? '0 : rs_rd_reg;
        col_old = (t_reg == 5'd1) ? '0 : cs_rd_reg;
    end

    // Next-state logic of the sequencer and the pipeline stages.
    always_comb
    begin
        state_next      = state_reg;
        horizon_next    = horizon_reg;
        node_count_next = node_count_reg;
        j_next = j_reg;
        k_next = k_reg;
        h_next = h_reg;
        t_next = t_reg;
        cl_next = cl_reg;
        ld_v_next = 1'b0;
        ld_idx_next = ld_idx_reg;
        ld_w_next = ld_w_reg;
        lw_v_next = 1'b0;
        lw_idx_next = lw_idx_reg;
        lw_w_next = lw_w_reg;
        m_v_next = 1'b0;
        m_first_next = m_first_reg;
        m_last_next = m_last_reg;
        m_diag_next = m_diag_reg;
        m_j_next = m_j_reg;
        m_k_next = m_k_reg;
        s_next = s_reg;
        a_v_next = 1'b0;
        a_first_next = a_first_reg;
        a_last_next = a_last_reg;
        a_j_next = a_j_reg;
        rt_next = rt_reg;
        ct_next = ct_reg;
        out_valid_next = out_valid_reg;
        node_next = node_reg;
        row_next = row_reg;
        col_next = col_reg;
        last_next = last_reg;

        w_we = 1'b0;
        w_waddr = ld_idx_reg;
        w_wdata = ld_w_reg;
        w_raddr = {IW'(from_node), IW'(to_node)};
        p_we = 1'b0;
        p_wa = {t_reg[0], m_j_reg, m_k_reg};
        p_wd = s_new;
        p_ra1 = {~t_reg[0], j_reg, h_reg};
        p_ra2 = {t_reg[0], k_reg, j_reg};
        s_we = 1'b0;
        s_re = 1'b0;
        s_wa = a_j_reg;
        s_ra = j_reg;
        r_wd = sat_add(row_old, rt_new >> t_reg);
        c_wd = sat_add(col_old, ct_new >> t_reg);

        // Configuration writes.
        if (cfg_valid)
        begin
            if (cfg_index == REG_HORIZON)
            begin
                horizon_next = cfg_data[4:0];
            end
            else
            begin
                node_count_next = cfg_data;
            end
        end

        // Edge load write-back; the previous write is forwarded past the read.
        if (ld_v_reg && (w_eff == W_NONE))
        begin
            w_we = 1'b1;
            lw_v_next = 1'b1;
            lw_idx_next = ld_idx_reg;
            lw_w_next = ld_w_reg;
        end

        // Multiply stage: one product term per cycle, written back at the row end.
        if (m_v_reg)
        begin
            s_next = s_new;
            if (m_last_reg)
            begin
                p_we = 1'b1;
            end
        end

        // Accumulate stage: row and column totals, folded into the sums at row end.
        if (a_v_reg)
        begin
            rt_next = rt_new;
            ct_next = ct_new;
            if (a_last_reg)
            begin
                s_we = 1'b1;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                w_we = 1'b1;
                w_waddr = cl_reg;
                w_wdata = W_NONE;
                cl_next = cl_reg + 1'b1;
                if (&cl_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        ld_v_next = in_range;
                        ld_idx_next = {IW'(from_node), IW'(to_node)};
                        ld_w_next = certain ? W_ONE : W_HALF;
                    end
                    else
                    begin
                        state_next = S_START;
                        t_next = 5'd1;
                        j_next = '0;
                        k_next = '0;
                        h_next = '0;
                    end
                end
            end
            S_START:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                w_raddr = {h_reg, k_reg};
                m_v_next = 1'b1;
                m_first_next = (h_reg == '0);
                m_last_next = (h_reg == nm1);
                m_diag_next = (j_reg == h_reg);
                m_j_next = j_reg;
                m_k_next = k_reg;
                if (h_reg == nm1)
                begin
                    h_next = '0;
                    if (k_reg == nm1)
                    begin
                        k_next = '0;
                        if (j_reg == nm1)
                        begin
                            j_next = '0;
                            state_next = S_MDRAIN;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    h_next = h_reg + 1'b1;
                end
            end
            S_MDRAIN:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                p_ra1 = {t_reg[0], j_reg, k_reg};
                a_v_next = 1'b1;
                a_first_next = (k_reg == '0);
                a_last_next = (k_reg == nm1);
                a_j_next = j_reg;
                s_re = (k_reg == '0);
                if (k_reg == nm1)
                begin
                    k_next = '0;
                    if (j_reg == nm1)
                    begin
                        j_next = '0;
                        state_next = S_ADRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_ADRAIN:
            begin
                if (t_reg == hz_eff)
                begin
                    state_next = S_OREAD;
                end
                else
                begin
                    t_next = t_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OREAD:
            begin
                s_re = 1'b1;
                state_next = S_OLOAD;
            end
            S_OLOAD:
            begin
                out_valid_next = 1'b1;
                node_next = 5'(j_reg);
                row_next = rs_rd_reg;
                col_next = cs_rd_reg;
                last_next = (j_reg == nm1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        cl_next = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = S_OREAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            horizon_reg    <= HORIZON_RESET;
            node_count_reg <= NODE_COUNT_RESET;
            j_reg          <= '0;
            k_reg          <= '0;
            h_reg          <= '0;
            t_reg          <= 5'd1;
            cl_reg         <= '0;
            ld_v_reg       <= 1'b0;
            lw_v_reg       <= 1'b0;
            m_v_reg        <= 1'b0;
            a_v_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            horizon_reg    <= horizon_next;
            node_count_reg <= node_count_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            h_reg          <= h_next;
            t_reg          <= t_next;
            cl_reg         <= cl_next;
            ld_v_reg       <= ld_v_next;
            lw_v_reg       <= lw_v_next;
            m_v_reg        <= m_v_next;
            a_v_reg        <= a_v_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        ld_idx_reg  <= ld_idx_next;
        ld_w_reg    <= ld_w_next;
        lw_idx_reg  <= lw_idx_next;
        lw_w_reg    <= lw_w_next;
        m_first_reg <= m_first_next;
        m_last_reg  <= m_last_next;
        m_diag_reg  <= m_diag_next;
        m_j_reg     <= m_j_next;
        m_k_reg     <= m_k_next;
        s_reg       <= s_next;
        a_first_reg <= a_first_next;
        a_last_reg  <= a_last_next;
        a_j_reg     <= a_j_next;
        rt_reg      <= rt_next;
        ct_reg      <= ct_next;
        node_reg    <= node_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
    end

endmodule

// ===== sv/dce_checker.sv =====
// Port-level checker for the diffusion centrality engine and its bind statement.
`include "assert_macros.svh"

module dce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       func,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] node,
    input logic       last
);
    import dce_pkg::*;

    // A run transaction makes the engine busy on the next cycle.
    `ASSERT_NXT(a_run_busy, clk, rst_n, in_valid && in_ready && (func == FUNC_RUN), !in_ready)

    // No input transaction is taken while a result is offered.
    `ASSERT_IMP(a_out_excl, clk, rst_n, out_valid, !in_ready)

    // After a result that is not the final one, the engine stays busy.
    `ASSERT_NXT(a_mid_busy, clk, rst_n, out_valid && out_ready && !last, !in_ready)

    // A stalled result holds its node and last flag.
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(node) && $stable(last))

endmodule

bind diffusion_centrality_engine_unit dce_checker u_dce_checker (.*);
